// ===== design/lde_pkg.sv =====
`default_nettype none
package lde_pkg;

    localparam int DIV_BITS = 32;               // quotient bits produced by the divider
    localparam int FRAC     = 24;               // fractional bits of normalized values
    localparam int DIV_LAT  = DIV_BITS + 1;     // divider register stages
    localparam int CFG_IDX_W = 2;

    localparam logic signed [31:0] ONE_Q24     = 32'sd16777216;
    localparam logic signed [31:0] K1_RESET    = 32'sd2630667;
    localparam logic signed [31:0] P0_RESET    = -32'sd397284;
    localparam logic signed [31:0] P1_RESET    = -32'sd794569;
    localparam logic signed [31:0] Q_MAX       = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN       = 32'sh80000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIAL = 2'd0,
        REG_TAN_A  = 2'd1,
        REG_TAN_B  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic              f;   // clipped
        logic signed [31:0] v;
    } t_satv;

    // point fields carried alongside the divider
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               corr;
    } t_side;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
    } t_coef;

    function automatic t_satv sat64(input logic signed [63:0] v);
        t_satv r;
        if (v > 64'(Q_MAX)) begin
            r.f = 1'b1;
            r.v = Q_MAX;
        end else if (v < 64'(Q_MIN)) begin
            r.f = 1'b1;
            r.v = Q_MIN;
        end else begin
            r.f = 1'b0;
            r.v = v[31:0];
        end
        return r;
    endfunction

    // signed quotient from magnitude quotient, overflow and sign
    function automatic t_satv sat_quo(input logic [31:0] q, input logic ovf, input logic neg);
        t_satv r;
        if (!neg) begin
            if (ovf || q[31]) begin
                r.f = 1'b1;
                r.v = Q_MAX;
            end else begin
                r.f = 1'b0;
                r.v = q;
            end
        end else begin
            if (ovf || (q > 32'h80000000)) begin
                r.f = 1'b1;
                r.v = Q_MIN;
            end else begin
                r.f = 1'b0;
                r.v = 32'(-q);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/lde_if.sv =====
`default_nettype none
interface lde_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface lde_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               corrected;
    logic               saturated;
    modport source (output valid, out_x, out_y, out_z, corrected, saturated, input ready);
    modport sink   (input valid, out_x, out_y, out_z, corrected, saturated, output ready);
endinterface

interface lde_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/lens_distortion_map.sv =====
// Brown-Conrady lens distortion of a point stream. Each point (x, y, z, Q16.16 metres)
// with positive depth is normalized to x/z, y/z in Q8.24 and distorted with one radial
// term (k1) and two tangential terms; depth passes through. Points with depth of zero
// or less come out unchanged with corrected low. Any clipped intermediate of a
// corrected point sets saturated. One point is accepted every cycle unless the
// pipeline holds (a result waits and the sink is not ready). The divider has 33
// stages (an entry stage, then one quotient bit each), the polynomial 7, the last
// being the output register. The user must write coefficients (configuration channel,
// always ready) while no point is in flight; the block does not enforce this.
`default_nettype none
module lens_distortion_map import lde_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lde_pt_if.sink    i_pt,
    lde_res_if.source o_res,
    lde_cfg_if.sink   i_cfg
);

    // pipeline moves whenever the output register is free or being emptied
    logic  adv;
    logic  out_valid;
    t_coef r_coef;
    t_side r_sd [0:DIV_LAT-1];
    logic [DIV_LAT-1:0] r_v;
    logic [31:0] mag_x, mag_y;
    logic [31:0] qx, qy;
    logic        ovfx, ovfy;
    t_side       in_side;

    assign adv         = !out_valid || o_res.ready;
    assign i_pt.ready  = adv;
    assign i_cfg.ready = 1'b1;

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.k1 <= K1_RESET;
            r_coef.p0 <= P0_RESET;
            r_coef.p1 <= P1_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RADIAL: r_coef.k1 <= i_cfg.data;
                REG_TAN_A:  r_coef.p0 <= i_cfg.data;
                REG_TAN_B:  r_coef.p1 <= i_cfg.data;
                default:    ;   // unused index, write dropped
            endcase
        end
    end

    // magnitudes for the unsigned divider; the quotient sign follows x (or y)
    always_comb begin
        mag_x        = i_pt.in_x[31] ? 32'(-i_pt.in_x) : i_pt.in_x;
        mag_y        = i_pt.in_y[31] ? 32'(-i_pt.in_y) : i_pt.in_y;
        in_side.x    = i_pt.in_x;
        in_side.y    = i_pt.in_y;
        in_side.z    = i_pt.in_z;
        in_side.corr = !i_pt.in_z[31] && (i_pt.in_z != '0);
    end

    lde_div u_div_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_mag (mag_x),
        .i_den (i_pt.in_z),
        .o_quo (qx),
        .o_ovf (ovfx)
    );

    lde_div u_div_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_mag (mag_y),
        .i_den (i_pt.in_z),
        .o_quo (qy),
        .o_ovf (ovfy)
    );

    // point fields and valid bits ride along with the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[DIV_LAT-2:0], i_pt.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sd[0] <= in_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    lde_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v[DIV_LAT-1]),
        .i_side  (r_sd[DIV_LAT-1]),
        .i_qx    (qx),
        .i_ovfx  (ovfx),
        .i_qy    (qy),
        .i_ovfy  (ovfy),
        .i_coef  (r_coef),
        .o_valid (out_valid),
        .o_x     (o_res.out_x),
        .o_y     (o_res.out_y),
        .o_z     (o_res.out_z),
        .o_corr  (o_res.corrected),
        .o_sat   (o_res.saturated)
    );

    assign o_res.valid = out_valid;

endmodule
`default_nettype wire

// ===== design/lde_div.sv =====
`default_nettype none
// pipelined restoring divider, an entry stage, then one quotient bit per stage
module lde_div import lde_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_mag,
    input  wire logic [31:0] i_den,
    output logic [31:0]      o_quo,
    output logic             o_ovf
);

    logic [31:0] r_rem [0:DIV_BITS];
    logic [31:0] r_quo [0:DIV_BITS];
    logic [31:0] r_mag [0:DIV_BITS];
    logic [31:0] r_den [0:DIV_BITS];
    logic        r_ovf [0:DIV_BITS];

    // quotient of 2^32 or more shows up as high dividend bits >= divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_mag >> (DIV_BITS - FRAC);
            r_quo[0] <= '0;
            r_mag[0] <= i_mag;
            r_den[0] <= i_den;
            r_ovf[0] <= (i_mag >> (DIV_BITS - FRAC)) >= i_den;
        end
    end

    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_stage
        localparam int J = DIV_BITS - k;
        logic        nbit;
        logic [32:0] tr;
        logic        ge;
        logic [31:0] n_rem;

        if (J >= FRAC) begin : g_hi
            assign nbit = r_mag[k-1][J-FRAC];
        end else begin : g_lo
            assign nbit = 1'b0;
        end

        always_comb begin
            tr    = {r_rem[k-1], nbit};
            ge    = tr >= {1'b0, r_den[k-1]};
            n_rem = ge ? 32'(tr - {1'b0, r_den[k-1]}) : tr[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= {r_quo[k-1][30:0], ge};
                r_mag[k] <= r_mag[k-1];
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_BITS];
    assign o_ovf = r_ovf[DIV_BITS];

endmodule
`default_nettype wire

// ===== design/lde_poly.sv =====
`default_nettype none
// distortion polynomial, seven register stages, last one is the output register
module lde_poly import lde_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_side       i_side,
    input  wire logic [31:0] i_qx,
    input  wire logic        i_ovfx,
    input  wire logic [31:0] i_qy,
    input  wire logic        i_ovfy,
    input  wire t_coef       i_coef,
    output logic             o_valid,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_z,
    output logic             o_corr,
    output logic             o_sat
);

    logic [6:0] r_v;
    t_side      r_sd  [0:5];
    logic       r_sf  [0:5];

    logic signed [31:0] r_xn_a, r_yn_a;
    logic signed [31:0] r_xx_b, r_yy_b, r_xy_b, r_xn_b, r_yn_b;
    logic signed [31:0] r_r2_c, r_sx_c, r_sy_c, r_xy_c, r_xn_c, r_yn_c;
    logic signed [31:0] r_kr_d, r_xt_d, r_yt_d, r_xn_d, r_yn_d;
    logic signed [31:0] r_fac_e, r_xt_e, r_yt_e, r_xn_e, r_yn_e;
    logic signed [31:0] r_xr_f, r_yr_f, r_xt_f, r_yt_f;
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic               r_oc, r_os;

    t_satv a_xn, a_yn;
    t_satv b_xx, b_yy, b_xy;
    t_satv c_r2, c_sx, c_sy;
    t_satv d_kr, d_xt, d_yt;
    t_satv e_fac;
    t_satv f_xr, f_yr;
    t_satv g_ox, g_oy;
    logic signed [63:0] p_xx, p_yy, p_xy, p_kr, p_ax, p_bx, p_ay, p_by, p_xr, p_yr;

    always_comb begin
        a_xn = sat_quo(i_qx, i_ovfx, i_side.x[31]);
        a_yn = sat_quo(i_qy, i_ovfy, i_side.y[31]);

        p_xx = 64'(r_xn_a) * 64'(r_xn_a);
        p_yy = 64'(r_yn_a) * 64'(r_yn_a);
        p_xy = 64'(r_xn_a) * 64'(r_yn_a);
        b_xx = sat64(p_xx >>> FRAC);
        b_yy = sat64(p_yy >>> FRAC);
        b_xy = sat64(p_xy >>> FRAC);

        c_r2 = sat64(64'(r_xx_b) + 64'(r_yy_b));
        c_sx = sat64(64'(c_r2.v) + 64'(r_xx_b) + 64'(r_xx_b));
        c_sy = sat64(64'(c_r2.v) + 64'(r_yy_b) + 64'(r_yy_b));

        p_kr = 64'(i_coef.k1) * 64'(r_r2_c);
        p_ax = 64'(i_coef.p0) * 64'(r_xy_c);
        p_bx = 64'(i_coef.p1) * 64'(r_sx_c);
        p_ay = 64'(i_coef.p0) * 64'(r_sy_c);
        p_by = 64'(i_coef.p1) * 64'(r_xy_c);
        d_kr = sat64(p_kr >>> 30);
        d_xt = sat64((p_ax >>> 29) + (p_bx >>> 30));
        d_yt = sat64((p_ay >>> 30) + (p_by >>> 29));

        e_fac = sat64(64'(ONE_Q24) + 64'(r_kr_d));

        p_xr = 64'(r_xn_e) * 64'(r_fac_e);
        p_yr = 64'(r_yn_e) * 64'(r_fac_e);
        f_xr = sat64(p_xr >>> FRAC);
        f_yr = sat64(p_yr >>> FRAC);

        g_ox = sat64(64'(r_xr_f) + 64'(r_xt_f));
        g_oy = sat64(64'(r_yr_f) + 64'(r_yt_f));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage a: signed, clipped quotients
            r_sd[0] <= i_side;
            r_sf[0] <= a_xn.f | a_yn.f;
            r_xn_a  <= a_xn.v;
            r_yn_a  <= a_yn.v;
            // stage b: squares and cross product
            r_sd[1] <= r_sd[0];
            r_sf[1] <= r_sf[0] | b_xx.f | b_yy.f | b_xy.f;
            r_xx_b  <= b_xx.v;
            r_yy_b  <= b_yy.v;
            r_xy_b  <= b_xy.v;
            r_xn_b  <= r_xn_a;
            r_yn_b  <= r_yn_a;
            // stage c: radius and tangential sums
            r_sd[2] <= r_sd[1];
            r_sf[2] <= r_sf[1] | c_r2.f | c_sx.f | c_sy.f;
            r_r2_c  <= c_r2.v;
            r_sx_c  <= c_sx.v;
            r_sy_c  <= c_sy.v;
            r_xy_c  <= r_xy_b;
            r_xn_c  <= r_xn_b;
            r_yn_c  <= r_yn_b;
            // stage d: coefficient products
            r_sd[3] <= r_sd[2];
            r_sf[3] <= r_sf[2] | d_kr.f | d_xt.f | d_yt.f;
            r_kr_d  <= d_kr.v;
            r_xt_d  <= d_xt.v;
            r_yt_d  <= d_yt.v;
            r_xn_d  <= r_xn_c;
            r_yn_d  <= r_yn_c;
            // stage e: radial factor
            r_sd[4] <= r_sd[3];
            r_sf[4] <= r_sf[3] | e_fac.f;
            r_fac_e <= e_fac.v;
            r_xt_e  <= r_xt_d;
            r_yt_e  <= r_yt_d;
            r_xn_e  <= r_xn_d;
            r_yn_e  <= r_yn_d;
            // stage f: radial scaling
            r_sd[5] <= r_sd[4];
            r_sf[5] <= r_sf[4] | f_xr.f | f_yr.f;
            r_xr_f  <= f_xr.v;
            r_yr_f  <= f_yr.v;
            r_xt_f  <= r_xt_e;
            r_yt_f  <= r_yt_e;
            // stage g: final sum, pass-through for non-positive depth
            r_oz <= r_sd[5].z;
            r_oc <= r_sd[5].corr;
            if (r_sd[5].corr) begin
                r_ox <= g_ox.v;
                r_oy <= g_oy.v;
                r_os <= r_sf[5] | g_ox.f | g_oy.f;
            end else begin
                r_ox <= r_sd[5].x;
                r_oy <= r_sd[5].y;
                r_os <= 1'b0;
            end
        end
    end

    assign o_valid = r_v[6];
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_z     = r_oz;
    assign o_corr  = r_oc;
    assign o_sat   = r_os;

endmodule
`default_nettype wire

// ===== design/lde_checker.sv =====
`default_nettype none
module lde_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_x,
    input wire logic [31:0] i_out_y,
    input wire logic [31:0] i_out_z,
    input wire logic        i_corr,
    input wire logic        i_sat
);

    // a waiting result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_z) && $stable(i_corr) && $stable(i_sat))
        else $error("stalled result changed");

    // input never blocked while the output is empty
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // pass-through points never report clipping
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_corr |-> !i_sat)
        else $error("uncorrected point flagged saturated");

    // corrected exactly when depth is positive
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_corr == (!i_out_z[31] && (i_out_z != 32'd0)))
        else $error("corrected flag disagrees with depth");

endmodule

bind lens_distortion_map lde_checker u_lde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_x     (o_res.out_x),
    .i_out_y     (o_res.out_y),
    .i_out_z     (o_res.out_z),
    .i_corr      (o_res.corrected),
    .i_sat       (o_res.saturated)
);
`default_nettype wire
